/* sv/sps_pkg.sv */
// Shared types and constants for the setpoint step schedule sequencer.
// No dependencies; every other file refers to it by scoped names.
package sps_pkg;

	localparam int MAX_STEPS_DEFAULT = 16;
	localparam int TEMP_W            = 8;
	localparam int PERIOD_W          = 32;

	typedef enum logic [2:0] {
		CMD_APPEND = 3'd0,
		CMD_CLEAR  = 3'd1,
		CMD_PLAY   = 3'd2,
		CMD_STOP   = 3'd3,
		CMD_TICK   = 3'd4
	} cmd_t;

	typedef struct packed {
		logic [TEMP_W-1:0]   temp;
		logic [PERIOD_W-1:0] period;
	} step_t;

endpackage

/* sv/sps_step_table.sv */
// Step table memory: one write port and one registered read port with
// same-cycle write bypass. Uses sps_pkg for the step entry type.
module sps_step_table #(
	parameter int DEPTH = sps_pkg::MAX_STEPS_DEFAULT,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  sps_pkg::step_t        wr_data,
	input  logic [AW-1:0]         rd_addr,
	output sps_pkg::step_t        rd_data
);

	sps_pkg::step_t mem [DEPTH];
	sps_pkg::step_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// a write to the address being read shows up at once
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_data_q <= wr_data;
		end else begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* sv/setpoint_step_schedule_sequencer.sv */
// Top level of the setpoint step schedule sequencer.
// Depends on sps_pkg and sps_step_table.
//
// Takes one command per clock cycle (append, clear, play, stop, tick) unless
// item_stall is high, and returns one result per command: the setpoint, the
// active step, the number of stored steps, the run flag and an append reject
// flag. A command passes through an input register and a single pass of
// sequencer logic into the result register. A new command can be taken every
// cycle unless a stalled result holds it back. The step after the active one is
// kept read ahead from the step table, and step 0 is held in registers, so
// play and tick never wait on the table's registered read port.
// The default setpoint must be written through the cfg port only while the block
// is idle, which the block does not enforce; it takes effect at the next stop.
module setpoint_step_schedule_sequencer #(
	parameter int MAX_STEPS = sps_pkg::MAX_STEPS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [sps_pkg::TEMP_W-1:0]    cfg_data,
	// commands
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [2:0]                    command,
	input  logic [sps_pkg::TEMP_W-1:0]    step_temperature,
	input  logic [sps_pkg::PERIOD_W-1:0]  step_period,
	// results
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [sps_pkg::TEMP_W-1:0]    setpoint,
	output logic [3:0]                    current_step,
	output logic [4:0]                    steps_stored,
	output logic                          running,
	output logic                          append_rejected
);

	localparam int IW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
	localparam int TW = $clog2(MAX_STEPS + 1);
	localparam logic [TW-1:0] MAX_TOTAL = TW'(MAX_STEPS);

	// input register
	logic                          valid_s1;
	logic [2:0]                    command_s1;
	logic [sps_pkg::TEMP_W-1:0]    temp_s1;
	logic [sps_pkg::PERIOD_W-1:0]  period_s1;

	// sequencer state
	logic [sps_pkg::TEMP_W-1:0]    default_q;
	logic [TW-1:0]                 total_q;
	logic [IW-1:0]                 active_q;
	logic [sps_pkg::PERIOD_W-1:0]  countdown_q;
	logic                          run_q;
	logic [sps_pkg::TEMP_W-1:0]    setpoint_q;
	sps_pkg::step_t                first_q;

	// result register
	logic                          res_valid_q;
	logic [sps_pkg::TEMP_W-1:0]    res_setpoint_q;
	logic [IW-1:0]                 res_active_q;
	logic [TW-1:0]                 res_total_q;
	logic                          res_run_q;
	logic                          res_rejected_q;

	logic                          fire;
	logic [TW-1:0]                 total_d;
	logic [IW-1:0]                 active_d;
	logic [sps_pkg::PERIOD_W-1:0]  countdown_d;
	logic                          run_d;
	logic [sps_pkg::TEMP_W-1:0]    setpoint_d;
	logic                          rejected_d;
	logic                          wr_en;
	logic                          first_wr;
	logic [TW-1:0]                 active_inc;
	logic [TW-1:0]                 next_idx;
	logic [IW-1:0]                 rd_addr;
	sps_pkg::step_t                wr_data;
	sps_pkg::step_t                next_step;
	logic [IW+3:0]                 active_ext;
	logic [TW+4:0]                 total_ext;

	assign fire       = valid_s1 & (~res_valid_q | ~result_stall);
	assign item_stall = valid_s1 & ~fire;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			command_s1 <= command;
			temp_s1    <= step_temperature;
			period_s1  <= step_period;
		end
	end

	assign active_inc   = TW'(active_q) + TW'(1);
	assign wr_data.temp   = temp_s1;
	assign wr_data.period = period_s1;

	always_comb begin
		total_d     = total_q;
		active_d    = active_q;
		countdown_d = countdown_q;
		run_d       = run_q;
		setpoint_d  = setpoint_q;
		rejected_d  = 1'b0;
		wr_en       = 1'b0;
		first_wr    = 1'b0;
		if (fire) begin
			unique case (sps_pkg::cmd_t'(command_s1))
				sps_pkg::CMD_APPEND: begin
					if (total_q < MAX_TOTAL) begin
						wr_en    = 1'b1;
						first_wr = (total_q == '0);
						total_d  = total_q + TW'(1);
					end else begin
						rejected_d = 1'b1;
					end
				end
				sps_pkg::CMD_CLEAR: begin
					total_d  = '0;
					active_d = '0;
				end
				sps_pkg::CMD_PLAY: begin
					if (total_q != '0) begin
						active_d    = '0;
						setpoint_d  = first_q.temp;
						countdown_d = first_q.period;
					end
					run_d = 1'b1;
				end
				sps_pkg::CMD_STOP: begin
					active_d   = '0;
					setpoint_d = default_q;
					run_d      = 1'b0;
				end
				sps_pkg::CMD_TICK: begin
					if (run_q) begin
						if (countdown_q != '0) begin
							countdown_d = countdown_q - sps_pkg::PERIOD_W'(1);
						end else if (active_inc < total_q) begin
							active_d    = active_inc[IW-1:0];
							setpoint_d  = next_step.temp;
							countdown_d = next_step.period;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// read ahead the step after the one that becomes active
	assign next_idx = TW'(active_d) + TW'(1);
	assign rd_addr  = (next_idx < MAX_TOTAL) ? next_idx[IW-1:0] : '0;

	sps_step_table #(
		.DEPTH (MAX_STEPS),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (total_q[IW-1:0]),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (next_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q   <= '0;
			total_q     <= '0;
			active_q    <= '0;
			countdown_q <= '0;
			run_q       <= 1'b0;
			setpoint_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				default_q <= cfg_data;
			end
			total_q     <= total_d;
			active_q    <= active_d;
			countdown_q <= countdown_d;
			run_q       <= run_d;
			setpoint_q  <= setpoint_d;
		end
	end

	always_ff @(posedge clk) begin
		if (first_wr) begin
			first_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_setpoint_q <= setpoint_d;
			res_active_q   <= active_d;
			res_total_q    <= total_d;
			res_run_q      <= run_d;
			res_rejected_q <= rejected_d;
		end
	end

	// outputs carry the low bits of index and count
	assign active_ext = {4'b0, res_active_q};
	assign total_ext  = {5'b0, res_total_q};

	assign result_valid    = res_valid_q;
	assign setpoint        = res_setpoint_q;
	assign current_step    = active_ext[3:0];
	assign steps_stored    = total_ext[4:0];
	assign running         = res_run_q;
	assign append_rejected = res_rejected_q;

endmodule
